// File: design/assert_macros.svh
// Assertion macros shared by the request/response retry queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define RRQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/rrq_pkg.sv
// Types and codes for the request/response retry queue.
// No dependencies; used by rrq_store and request_response_retry_queue.
package rrq_pkg;

  localparam int TAG_W = 16;
  localparam int BYTE_W = 8;
  localparam int RETRY_W = 3;
  localparam int CMD_W = 3;
  localparam int EV_W = 4;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 64;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEND     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESPONSE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  // Events
  localparam logic [EV_W-1:0] EV_NONE      = 4'd0;
  localparam logic [EV_W-1:0] EV_QUEUED    = 4'd1;
  localparam logic [EV_W-1:0] EV_FULL      = 4'd2;
  localparam logic [EV_W-1:0] EV_SENT      = 4'd3;
  localparam logic [EV_W-1:0] EV_NOT_SENT  = 4'd4;
  localparam logic [EV_W-1:0] EV_MATCHED   = 4'd5;
  localparam logic [EV_W-1:0] EV_UNMATCHED = 4'd6;
  localparam logic [EV_W-1:0] EV_RETRIED   = 4'd7;
  localparam logic [EV_W-1:0] EV_TIMED_OUT = 4'd8;
  localparam logic [EV_W-1:0] EV_CLEARED   = 4'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [RETRY_W-1:0] RETRIES_RESET = 3'd2;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BYTE_W-1:0]  exp_rsp;
    logic               match_on;
    logic [BYTE_W-1:0]  idx;
    logic [RETRY_W-1:0] retries;
  } req_t;

endpackage

// File: design/request_response_retry_queue.sv
// Request/response queue with timeout and retry: top level.
// Depends on rrq_pkg, rrq_store and assert_macros.svh.
//
//  channel  | dir | tvalid/tready        | payload
//  ---------+-----+---------------------+------------------------------------
//  in_      | in  | in_tvalid/in_tready | tuser: command; tdata: request fields
//  out_     | out | out_tvalid/tready   | tuser: event_res; tdata: tag, count
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One command is taken per cycle unless a stalled result holds the flow; its
// result passes through the input register, then the result register.
// The front entry comes from the store's registered read port, addressed
// with the next head pointer and bypassed on a write to that address.
// Reset (rst_n low, synchronous) empties the queue and drops both stages.
// A stalled result holds the result register; the input register then holds
// too, and in_tready falls once both are full.
// cfg_ready is always high; writes to indexes beyond the list are ignored.
`include "assert_macros.svh"

module request_response_retry_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] command
  input  logic [rrq_pkg::CMD_W-1:0]         in_tuser,
  // [15:0] request_tag, [23:16] expected_response, [24] match_enable,
  // [32:25] match_index, [40:33] response_command, [48:41] response_item,
  // [56:49] payload_length, [63:57] zero
  input  logic [rrq_pkg::IN_DATA_W-1:0]     in_tdata,

  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] event_res
  output logic [rrq_pkg::EV_W-1:0]          out_tuser,
  // [15:0] result_tag, then pending_count, zero fill to whole bytes
  output logic [((rrq_pkg::TAG_W + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                            out_tdata,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W = ((rrq_pkg::TAG_W + CNT_W + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - rrq_pkg::TAG_W - CNT_W;
  localparam logic [AW:0]    DEPTH_SUM = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // Configuration
  logic [rrq_pkg::TICK_W-1:0]  timeout_r;
  logic [rrq_pkg::RETRY_W-1:0] max_retries_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= rrq_pkg::TIMEOUT_RESET;
      max_retries_r <= rrq_pkg::RETRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rrq_pkg::CFG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end else if (cfg_index == rrq_pkg::CFG_MAX_RETRIES) begin
        max_retries_r <= cfg_data[rrq_pkg::RETRY_W-1:0];
      end
    end
  end

  // Input register
  logic                          s1_v_r;
  logic [rrq_pkg::CMD_W-1:0]     s1_cmd_r;
  logic [rrq_pkg::IN_DATA_W-1:0] s1_data_r;
  logic                          advance;

  logic                          out_v_r;
  logic [rrq_pkg::EV_W-1:0]      out_ev_r;
  logic [rrq_pkg::TAG_W-1:0]     out_tag_r;
  logic [CNT_W-1:0]              out_pend_r;

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // Unpack the registered item
  logic [rrq_pkg::TAG_W-1:0]  f_tag;
  logic [rrq_pkg::BYTE_W-1:0] f_exp;
  logic                       f_match_en;
  logic [rrq_pkg::BYTE_W-1:0] f_match_idx;
  logic [rrq_pkg::BYTE_W-1:0] f_rsp_cmd;
  logic [rrq_pkg::BYTE_W-1:0] f_rsp_item;
  logic [rrq_pkg::BYTE_W-1:0] f_len;

  assign f_tag       = s1_data_r[15:0];
  assign f_exp       = s1_data_r[23:16];
  assign f_match_en  = s1_data_r[24];
  assign f_match_idx = s1_data_r[32:25];
  assign f_rsp_cmd   = s1_data_r[40:33];
  assign f_rsp_item  = s1_data_r[48:41];
  assign f_len       = s1_data_r[56:49];

  // Queue state
  logic [AW-1:0]              head_r, head_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       await_r, await_nxt;
  rrq_pkg::req_t              cur_r, cur_nxt;
  logic [rrq_pkg::TICK_W-1:0] el_r, el_nxt;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  rrq_pkg::req_t              wr_data;
  rrq_pkg::req_t              front;

  logic [rrq_pkg::EV_W-1:0]   ev_nxt;
  logic [rrq_pkg::TAG_W-1:0]  tag_nxt;

  logic [CNT_W-1:0]           pend;
  logic [AW:0]                tail_sum;
  logic [AW-1:0]              tail;
  logic [AW-1:0]              head_inc;
  logic [AW-1:0]              head_dec;
  logic [rrq_pkg::TICK_W-1:0] el_inc;
  logic                       rsp_ok;

  rrq_store #(
    .DEPTH(QUEUE_DEPTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .rst_n(rst_n),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(head_nxt),
    .rd_data(front)
  );

  always_comb begin
    pend     = cnt_r + CNT_W'(await_r);
    tail_sum = (AW + 1)'(head_r) + (AW + 1)'(cnt_r);
    if (tail_sum >= DEPTH_SUM) begin
      tail_sum = tail_sum - DEPTH_SUM;
    end
    tail     = tail_sum[AW-1:0];
    head_inc = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
    head_dec = (head_r == '0) ? LAST_ADDR : head_r - 1'b1;
    el_inc   = (el_r == '1) ? el_r : el_r + 1'b1;
    rsp_ok   = await_r && (f_rsp_cmd == cur_r.exp_rsp);
    if (cur_r.match_on) begin
      rsp_ok = rsp_ok && (f_len >= 8'd2) && (f_rsp_item == cur_r.idx);
    end

    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    await_nxt = await_r;
    cur_nxt   = cur_r;
    el_nxt    = el_r;
    wr_en     = 1'b0;
    wr_addr   = tail;
    wr_data   = '{tag: f_tag, exp_rsp: f_exp, match_on: f_match_en,
                  idx: f_match_idx, retries: '0};
    ev_nxt    = rrq_pkg::EV_NONE;
    tag_nxt   = '0;

    if (advance) begin
      case (s1_cmd_r)
        rrq_pkg::CMD_ENQUEUE: begin
          if (pend >= DEPTH_CNT) begin
            ev_nxt = rrq_pkg::EV_FULL;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            ev_nxt  = rrq_pkg::EV_QUEUED;
          end
        end
        rrq_pkg::CMD_SEND: begin
          if (await_r || (cnt_r == '0)) begin
            ev_nxt = rrq_pkg::EV_NOT_SENT;
          end else begin
            cur_nxt   = front;
            head_nxt  = head_inc;
            cnt_nxt   = cnt_r - 1'b1;
            el_nxt    = '0;
            await_nxt = (front.exp_rsp != '0);
            ev_nxt    = rrq_pkg::EV_SENT;
            tag_nxt   = front.tag;
          end
        end
        rrq_pkg::CMD_RESPONSE: begin
          if (rsp_ok) begin
            await_nxt = 1'b0;
            ev_nxt    = rrq_pkg::EV_MATCHED;
            tag_nxt   = cur_r.tag;
          end else begin
            ev_nxt = rrq_pkg::EV_UNMATCHED;
          end
        end
        rrq_pkg::CMD_TICK: begin
          if (await_r) begin
            el_nxt = el_inc;
            if (el_inc >= timeout_r) begin
              await_nxt = 1'b0;
              tag_nxt   = cur_r.tag;
              if (cur_r.retries < max_retries_r) begin
                // Push back to the front with one more retry used
                cur_nxt.retries = cur_r.retries + 1'b1;
                head_nxt = head_dec;
                wr_en    = 1'b1;
                wr_addr  = head_dec;
                wr_data  = cur_nxt;
                cnt_nxt  = cnt_r + 1'b1;
                el_nxt   = '0;
                ev_nxt   = rrq_pkg::EV_RETRIED;
              end else begin
                ev_nxt = rrq_pkg::EV_TIMED_OUT;
              end
            end
          end
        end
        rrq_pkg::CMD_CLEAR: begin
          head_nxt  = '0;
          cnt_nxt   = '0;
          await_nxt = 1'b0;
          el_nxt    = '0;
          ev_nxt    = rrq_pkg::EV_CLEARED;
        end
        default: begin
          ev_nxt = rrq_pkg::EV_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      cnt_r   <= '0;
      await_r <= 1'b0;
      cur_r   <= '0;
      el_r    <= '0;
    end else begin
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      await_r <= await_nxt;
      cur_r   <= cur_nxt;
      el_r    <= el_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev_r   <= ev_nxt;
      out_tag_r  <= tag_nxt;
      out_pend_r <= cnt_nxt + CNT_W'(await_nxt);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_pend_r, out_tag_r};

  // Checks
  `RRQ_ASSERT(a_pending_bound, clk, rst_n, (cnt_r + CNT_W'(await_r)) <= DEPTH_CNT, "pending count over queue depth")
  `RRQ_ASSERT(a_clear_empties, clk, rst_n, advance && (s1_cmd_r == rrq_pkg::CMD_CLEAR) |=> (cnt_r == '0) && !await_r, "clear left entries behind")
  `RRQ_ASSERT(a_retry_requeues, clk, rst_n, advance && (ev_nxt == rrq_pkg::EV_RETRIED) |=> (cnt_r == $past(cnt_r) + 1'b1) && !await_r, "retry did not requeue")
  `RRQ_ASSERT(a_send_blocked, clk, rst_n, advance && (s1_cmd_r == rrq_pkg::CMD_SEND) && await_r |=> (head_r == $past(head_r)) && (cnt_r == $past(cnt_r)), "send moved the queue while waiting")

endmodule

// File: design/rrq_store.sv
// Request ring storage: one write port, one registered read port with
// same-cycle write bypass. Depends on rrq_pkg for the entry type.
module rrq_store #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  rrq_pkg::req_t  wr_data,
  input  logic [AW-1:0]  rd_addr,
  output rrq_pkg::req_t  rd_data
);

  rrq_pkg::req_t mem [DEPTH];
  rrq_pkg::req_t rd_q_r;
  rrq_pkg::req_t byp_data_r;
  logic          byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  // Take the written word when it lands on the address being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

// File: dv/request_response_retry_queue_tb.sv
// Self-checking testbench for the request/response retry queue.
// Depends on rrq_pkg and the request_response_retry_queue top level; drives all
// three channels and predicts each result from its own copy of the queue state.
module request_response_retry_queue_tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DATA_W = ((rrq_pkg::TAG_W + CNT_W + 7) / 8) * 8;
  localparam int LONG_STALL = 300;

  // Field positions inside in_tdata
  localparam int EXP_LSB  = 16;
  localparam int MEN_LSB  = 24;
  localparam int IDX_LSB  = 25;
  localparam int RCMD_LSB = 33;
  localparam int ITEM_LSB = 41;
  localparam int LEN_LSB  = 49;

  typedef struct packed {
    logic [rrq_pkg::EV_W-1:0]  ev;
    logic [rrq_pkg::TAG_W-1:0] tag;
    logic [CNT_W-1:0]          pend;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // [2:0] command
  logic [rrq_pkg::CMD_W-1:0]      in_tuser = '0;
  // [15:0] request_tag, [23:16] expected_response, [24] match_enable,
  // [32:25] match_index, [40:33] response_command, [48:41] response_item,
  // [56:49] payload_length, [63:57] zero
  logic [rrq_pkg::IN_DATA_W-1:0]  in_tdata = '0;

  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [3:0] event_res
  logic [rrq_pkg::EV_W-1:0]       out_tuser;
  // [15:0] result_tag, [20:16] pending_count, [23:21] zero
  logic [OUT_DATA_W-1:0]          out_tdata;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rrq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rrq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  request_response_retry_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue: ring store, pointers, the request in flight
  // and the two registers.
  rrq_pkg::req_t                m_store [QUEUE_DEPTH];
  logic [AW-1:0]                m_head = '0;
  logic [CNT_W-1:0]             m_count = '0;
  logic                         m_waiting = 1'b0;
  rrq_pkg::req_t                m_current = '0;
  logic [rrq_pkg::TICK_W-1:0]   m_elapsed = '0;
  logic [rrq_pkg::TICK_W-1:0]   m_timeout = rrq_pkg::TIMEOUT_RESET;
  logic [rrq_pkg::RETRY_W-1:0]  m_retry_limit = rrq_pkg::RETRIES_RESET;

  outcome_t predicted_events [$];

  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned error_count = 0;
  int unsigned event_seen [16];
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned ready_hold = 0;
  logic        sink_steady = 1'b0;
  logic        sender_steady = 1'b0;
  // Set while in_tvalid is left high after a transfer
  logic        in_held = 1'b0;

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi, lo);
    return v[7:0];
  endfunction

  function automatic logic [rrq_pkg::IN_DATA_W-1:0] random_fields();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {7'b0, r[56:0]};
  endfunction

  function automatic logic [rrq_pkg::IN_DATA_W-1:0] pack_fields(
    input logic [15:0] tag, input logic [7:0] exp_rsp, input logic men,
    input logic [7:0] midx, input logic [7:0] rcmd, input logic [7:0] item,
    input logic [7:0] len);
    return {7'b0, len, item, rcmd, midx, men, exp_rsp, tag};
  endfunction

  // A random request; a quarter of them are fire-and-forget.
  function automatic logic [rrq_pkg::IN_DATA_W-1:0] request_fields();
    logic [rrq_pkg::IN_DATA_W-1:0] d;
    d = random_fields();
    if ($urandom_range(3) == 0) d[EXP_LSB +: 8] = 8'd0;
    return d;
  endfunction

  // Advance the shadow queue by one command and record the event it raises.
  task automatic apply_command(input logic [rrq_pkg::CMD_W-1:0] cmd,
                               input logic [rrq_pkg::IN_DATA_W-1:0] d);
    outcome_t      o;
    rrq_pkg::req_t r;
    logic [AW-1:0] slot;
    logic          ok;
    o.ev = rrq_pkg::EV_NONE;
    o.tag = '0;
    case (cmd)
      rrq_pkg::CMD_ENQUEUE: begin
        // An awaited request keeps its slot reserved so a retry always fits.
        if (int'(m_count) + int'(m_waiting) >= QUEUE_DEPTH) begin
          o.ev = rrq_pkg::EV_FULL;
        end else begin
          slot = m_head + m_count[AW-1:0];
          r.tag = d[15:0];
          r.exp_rsp = d[EXP_LSB +: 8];
          r.match_on = d[MEN_LSB];
          r.idx = d[IDX_LSB +: 8];
          r.retries = '0;
          m_store[slot] = r;
          m_count = m_count + 1'b1;
          o.ev = rrq_pkg::EV_QUEUED;
        end
      end
      rrq_pkg::CMD_SEND: begin
        if (m_waiting || m_count == 0) begin
          o.ev = rrq_pkg::EV_NOT_SENT;
        end else begin
          m_current = m_store[m_head];
          m_head = m_head + 1'b1;
          m_count = m_count - 1'b1;
          m_elapsed = '0;
          m_waiting = (m_current.exp_rsp != 8'd0);
          o.ev = rrq_pkg::EV_SENT;
          o.tag = m_current.tag;
        end
      end
      rrq_pkg::CMD_RESPONSE: begin
        ok = m_waiting && (d[RCMD_LSB +: 8] == m_current.exp_rsp);
        if (ok && m_current.match_on)
          ok = (d[LEN_LSB +: 8] >= 8'd2) && (d[ITEM_LSB +: 8] == m_current.idx);
        if (ok) begin
          m_waiting = 1'b0;
          o.ev = rrq_pkg::EV_MATCHED;
          o.tag = m_current.tag;
        end else begin
          o.ev = rrq_pkg::EV_UNMATCHED;
        end
      end
      rrq_pkg::CMD_TICK: begin
        if (m_waiting) begin
          if (m_elapsed != 16'hFFFF) m_elapsed = m_elapsed + 1'b1;
          if (m_elapsed >= m_timeout) begin
            m_waiting = 1'b0;
            o.tag = m_current.tag;
            if (m_current.retries < m_retry_limit) begin
              // Put it back at the front, carrying its retry count.
              m_current.retries = m_current.retries + 1'b1;
              m_head = m_head - 1'b1;
              m_store[m_head] = m_current;
              m_count = m_count + 1'b1;
              m_elapsed = '0;
              o.ev = rrq_pkg::EV_RETRIED;
            end else begin
              o.ev = rrq_pkg::EV_TIMED_OUT;
            end
          end
        end
      end
      rrq_pkg::CMD_CLEAR: begin
        m_head = '0;
        m_count = '0;
        m_waiting = 1'b0;
        m_elapsed = '0;
        o.ev = rrq_pkg::EV_CLEARED;
      end
      default: ;
    endcase
    o.pend = m_count + m_waiting;
    predicted_events.insert(predicted_events.size(), o);
  endtask

  // Offer one command, hold it until the transfer, then predict and, at random, idle.
  task automatic send_command(input logic [rrq_pkg::CMD_W-1:0] cmd,
                              input logic [rrq_pkg::IN_DATA_W-1:0] d);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= d;
    in_held = 1'b1;
    do @(posedge clk); while (!in_tready);
    apply_command(cmd, d);
    items_sent++;
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Withdraw an offer left standing after the last transfer.
  task automatic release_input();
    if (in_held) begin
      in_tvalid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  task automatic write_register(input logic [rrq_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rrq_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rrq_pkg::CFG_TIMEOUT:     m_timeout = value;
      rrq_pkg::CFG_MAX_RETRIES: m_retry_limit = value[rrq_pkg::RETRY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Every command yields a result, so an empty prediction queue means idle.
  task automatic wait_drained();
    release_input();
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Result side: drive tready with random gaps, serve long hold-offs on
  // request, and compare every transfer with the oldest prediction.
  always @(posedge clk) begin : result_side
    outcome_t    want;
    int unsigned gap;
    if ($urandom_range(299) == 0) sink_steady <= !sink_steady;
    if (stall_requests != stall_served) begin
      stall_served <= stall_served + 1;
      ready_hold <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_steady || $urandom_range(3) != 0) begin
      out_tready <= 1'b1;
    end else begin
      gap = pick_gap();
      out_tready <= (gap == 0);
      if (gap != 0) ready_hold <= gap - 1;
    end

    if (rst_n && out_tvalid && out_tready) begin
      event_seen[out_tuser]++;
      if (predicted_events.size() == 0) begin
        if (error_count < 10)
          $display("%0t: result with nothing predicted: event %0d tag %h",
                   $time, out_tuser, out_tdata[rrq_pkg::TAG_W-1:0]);
        error_count++;
      end else begin
        want = predicted_events[0];
        predicted_events.delete(0);
        if (out_tuser !== want.ev || out_tdata[rrq_pkg::TAG_W-1:0] !== want.tag ||
            out_tdata[rrq_pkg::TAG_W +: CNT_W] !== want.pend ||
            out_tdata[OUT_DATA_W-1:rrq_pkg::TAG_W+CNT_W] !== '0) begin
          if (error_count < 10)
            $display("%0t: mismatch: expected event %0d tag %h count %0d, ",
                     $time, want.ev, want.tag, want.pend,
                     "got event %0d tag %h count %0d fill %h", out_tuser,
                     out_tdata[rrq_pkg::TAG_W-1:0], out_tdata[rrq_pkg::TAG_W +: CNT_W],
                     out_tdata[OUT_DATA_W-1:rrq_pkg::TAG_W+CNT_W]);
          error_count++;
        end
      end
    end
  end

  // Commands on an idle queue, unused codes and a clear.
  task automatic test_idle_commands();
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_RESPONSE,
                 pack_fields(16'h0, 8'h0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0));
    send_command(rrq_pkg::CMD_TICK, random_fields());
    for (int c = int'(rrq_pkg::CMD_CLEAR) + 1; c < (1 << rrq_pkg::CMD_W); c++)
      send_command(c[rrq_pkg::CMD_W-1:0], random_fields());
    send_command(rrq_pkg::CMD_CLEAR, '1 >> 7);
  endtask

  // Full request life: index matching with each way to miss, then a
  // fire-and-forget request that leaves the queue idle.
  task automatic test_request_cycle();
    send_command(rrq_pkg::CMD_ENQUEUE,
                 pack_fields(16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'h0, 8'h0, 8'h0));
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_RESPONSE,
                 pack_fields(16'h0, 8'h0, 1'b0, 8'h0, 8'hFE, 8'hFF, 8'hFF));
    send_command(rrq_pkg::CMD_RESPONSE,
                 pack_fields(16'h0, 8'h0, 1'b0, 8'h0, 8'hFF, 8'hFF, 8'h01));
    send_command(rrq_pkg::CMD_RESPONSE,
                 pack_fields(16'h0, 8'h0, 1'b0, 8'h0, 8'hFF, 8'h00, 8'hFF));
    send_command(rrq_pkg::CMD_RESPONSE,
                 pack_fields(16'h0, 8'h0, 1'b0, 8'h0, 8'hFF, 8'hFF, 8'h02));
    send_command(rrq_pkg::CMD_ENQUEUE,
                 pack_fields(16'h0000, 8'h00, 1'b0, 8'h00, 8'h0, 8'h0, 8'h0));
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_SEND, '0);
  endtask

  // Shortest timeout: one resend, then the final timeout; then a send
  // refused while a reply is awaited, and a clear with a request in flight.
  task automatic test_timeout_retry();
    wait_drained();
    write_register(rrq_pkg::CFG_TIMEOUT, 16'd1);
    write_register(rrq_pkg::CFG_MAX_RETRIES, 16'd1);
    settings_used++;
    send_command(rrq_pkg::CMD_ENQUEUE,
                 pack_fields(16'h8001, 8'h01, 1'b0, 8'h00, 8'h0, 8'h0, 8'h0));
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_TICK, '0);
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_TICK, '0);
    send_command(rrq_pkg::CMD_ENQUEUE,
                 pack_fields(16'h7FFE, 8'h80, 1'b1, 8'h01, 8'h0, 8'h0, 8'h0));
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_SEND, '0);
    send_command(rrq_pkg::CMD_CLEAR, '0);
  endtask

  // Phases of random traffic, each under its own register setting. Most of
  // it is send/tick/response exchanges against the request in flight.
  task automatic test_random_traffic();
    int unsigned stop_at, n, k, pick, v;
    logic [rrq_pkg::TICK_W-1:0] tmo;
    logic [rrq_pkg::RETRY_W-1:0] lim;
    logic [rrq_pkg::CFG_DATA_W-1:0] raw;
    logic [rrq_pkg::IN_DATA_W-1:0] d;
    logic [rrq_pkg::CMD_W-1:0] cmd;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin tmo = 16'd1;                  lim = 3'd0; end
        1: begin tmo = 16'hFFFF;               lim = 3'd7; end
        2: begin tmo = 16'd2;                  lim = 3'd7; end
        3: begin tmo = rrq_pkg::TIMEOUT_RESET; lim = rrq_pkg::RETRIES_RESET; end
        default: begin
          v = $urandom_range(1, 8);
          tmo = v[rrq_pkg::TICK_W-1:0];
          v = $urandom_range(0, 7);
          lim = v[rrq_pkg::RETRY_W-1:0];
        end
      endcase
      wait_drained();
      // Writes beyond the register list must leave both registers alone.
      if (phase == 4) begin
        v = $urandom;
        write_register(rrq_pkg::CFG_MAX_RETRIES + 1'b1, v[rrq_pkg::CFG_DATA_W-1:0]);
      end
      write_register(rrq_pkg::CFG_TIMEOUT, tmo);
      v = $urandom;
      raw = v[rrq_pkg::CFG_DATA_W-1:0];
      raw[rrq_pkg::RETRY_W-1:0] = lim;
      write_register(rrq_pkg::CFG_MAX_RETRIES, raw);
      settings_used++;

      stop_at = items_sent + 165;
      while (items_sent < stop_at) begin
        if ($urandom_range(19) == 0) sender_steady = !sender_steady;
        pick = $urandom_range(99);
        if (pick < 25) begin
          // Bursts of requests; the long ones run into a full queue.
          n = ($urandom_range(9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 4);
          repeat (n) send_command(rrq_pkg::CMD_ENQUEUE, request_fields());
        end else if (pick < 78) begin
          send_command(rrq_pkg::CMD_SEND, random_fields());
          n = (m_timeout <= 8) ? $urandom_range(0, m_timeout + 1) : $urandom_range(0, 3);
          for (k = 0; k < n && m_waiting; k++)
            send_command(rrq_pkg::CMD_TICK, random_fields());
          if (m_waiting && $urandom_range(9) < 7) begin
            d = random_fields();
            d[RCMD_LSB +: 8] = m_current.exp_rsp;
            d[ITEM_LSB +: 8] = m_current.idx;
            d[LEN_LSB +: 8] = ($urandom_range(3) == 0) ? 8'd2 : rand_byte(2, 255);
            if ($urandom_range(3) == 0) begin
              // Spoil exactly one thing the match depends on.
              case ($urandom_range(2))
                0: d[RCMD_LSB +: 8] = d[RCMD_LSB +: 8] ^ rand_byte(1, 255);
                1: d[ITEM_LSB +: 8] = d[ITEM_LSB +: 8] ^ rand_byte(1, 255);
                default: d[LEN_LSB +: 8] = rand_byte(0, 1);
              endcase
            end
            send_command(rrq_pkg::CMD_RESPONSE, d);
          end
        end else begin
          // Noise: any code with random content, clears kept rare.
          v = $urandom_range(0, (1 << rrq_pkg::CMD_W) - 1);
          cmd = v[rrq_pkg::CMD_W-1:0];
          if (cmd == rrq_pkg::CMD_CLEAR && $urandom_range(3) != 0) cmd = rrq_pkg::CMD_TICK;
          send_command(cmd, random_fields());
        end
      end
    end
    sender_steady = 1'b0;
  endtask

  // Hold off the result side for a long stretch while commands keep coming,
  // so both pipeline stages fill and in_tready drops.
  task automatic test_backpressure();
    int unsigned pick;
    wait_drained();
    write_register(rrq_pkg::CFG_TIMEOUT, 16'd3);
    write_register(rrq_pkg::CFG_MAX_RETRIES, 16'd7);
    settings_used++;
    sender_steady = 1'b1;
    stall_requests <= stall_requests + 1;
    repeat (60) begin
      pick = $urandom_range(2);
      case (pick)
        0: send_command(rrq_pkg::CMD_ENQUEUE, request_fields());
        1: send_command(rrq_pkg::CMD_SEND, random_fields());
        default: send_command(rrq_pkg::CMD_TICK, random_fields());
      endcase
    end
    sender_steady = 1'b0;
  endtask

  initial begin : main_sequence
    int unsigned waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_request_cycle();
    test_timeout_retry();
    test_random_traffic();
    test_backpressure();
    release_input();

    waited = 0;
    while (predicted_events.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (predicted_events.size() != 0) begin
      $display("%0d predicted results never arrived", predicted_events.size());
      error_count++;
    end

    $display("Ran %0d commands under %0d register settings, %0d errors.",
             items_sent, settings_used, error_count);
    $display("Seen: %0d queued, %0d full, %0d sent, %0d matched, ",
             event_seen[rrq_pkg::EV_QUEUED], event_seen[rrq_pkg::EV_FULL],
             event_seen[rrq_pkg::EV_SENT], event_seen[rrq_pkg::EV_MATCHED],
             "%0d retried, %0d timed out.",
             event_seen[rrq_pkg::EV_RETRIED], event_seen[rrq_pkg::EV_TIMED_OUT]);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("Watchdog expired with %0d results outstanding", predicted_events.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
